[hdl/sca_pkg.sv]
// Shared constants, codes and types of the size-class allocator.
package sca_pkg;

   localparam int BLOCK_BYTES  = 4096;
   localparam int NUM_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;
   localparam int NUM_CLASSES  = 16;
   localparam int CARVE_COUNT  = 6;

   localparam int ADDR_W      = 18;
   localparam int GRAN_W      = 15;
   localparam int SIZE_W      = 13;
   localparam int REQ_W       = 16;
   localparam int CLS_W       = $clog2(NUM_CLASSES);
   localparam int OPEN_W      = $clog2(NUM_BLOCKS + 1);
   localparam int CNT_W       = $clog2(CARVE_COUNT + 1);
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int GRAN_BYTES  = 8;
   localparam int LARGEST     = GRAN_BYTES * NUM_CLASSES;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_MEMORY = 2'd1,
      STATUS_BAD_FREE  = 2'd2,
      STATUS_TOO_LARGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] sum;
      logic [SIZE_W-1:0] diff;
      logic              ge;
   } step_type;

endpackage

[hdl/sca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sca_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/sca_step_unit.sv]
// Shared bump unit: advances an address and takes a step off a remaining size.
module sca_step_unit (
   input  logic [sca_pkg::ADDR_W-1:0] ptr,
   input  logic [sca_pkg::SIZE_W-1:0] rem,
   input  logic [sca_pkg::SIZE_W-1:0] step,
   output sca_pkg::step_type          result
);
   import sca_pkg::*;

   always_comb begin
      result.sum  = ptr + ADDR_W'(step);
      result.diff = rem - step;
      result.ge   = (rem >= step);
   end
endmodule

[hdl/size_class_allocator.sv]
// Top level of the size-class allocator: sequencer, class heads and pool state.
//
// Requests enter on req_ (tuser = kind: 0 allocate, 1 free; tdata = request
// bytes, free address). One result per request leaves on rsp_ (data address,
// status). The block takes one request at a time: req_tready is high only when
// the sequencer is idle and the previous result has been taken.
// An allocate is served from its class free list or by carving from the pool;
// a large allocate takes its space from the pool. A free of a class block is
// pushed on its class list; a free of a large block is split into class chunks
// pushed one at a time. All steps run through one shared add/compare unit and
// one write port per memory.
// The next request can be accepted in the cycle after the result is taken.
// After reset the block clears all 32768 entries of the allocated-mark memory,
// one entry a cycle, before it accepts a request. A result is held on rsp_
// until rsp_tready; no new request is taken while it waits.
module size_class_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,   // kind
   input  logic [sca_pkg::REQ_TDATA_W-1:0]  req_tdata,   // request_bytes[15:0], free_address[33:16]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sca_pkg::RSP_TDATA_W-1:0]  rsp_tdata    // data_address[17:0], status[19:18]
);
   import sca_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_POP_WAIT, ST_POOL, ST_CARVE,
      ST_GRANT, ST_FREE_WAIT, ST_SPLIT, ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [GRAN_W-1:0]     clr_ff, clr_in;
   logic                  kind_ff, kind_in;
   logic [REQ_W-1:0]      req_ff, req_in;
   logic [ADDR_W-1:0]     fa_ff, fa_in;
   logic                  small_ff, small_in;
   logic [CLS_W-1:0]      cls_ff, cls_in;
   logic [ADDR_W-1:0]     blk_ff, blk_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [SIZE_W-1:0]     rem_ff, rem_in;
   logic [SIZE_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     pool_ptr_ff, pool_ptr_in;
   logic [SIZE_W-1:0]     pool_rem_ff, pool_rem_in;
   logic [OPEN_W-1:0]     opened_ff, opened_in;
   logic [GRAN_W:0]       head_ff [NUM_CLASSES];
   logic [GRAN_W:0]       head_in [NUM_CLASSES];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   status_type            rsp_status_ff, rsp_status_in;

   step_type              step_res;
   logic                  link_we, mark_we, mark_wd, size_we;
   logic [GRAN_W-1:0]     link_wa, link_wd, mark_wa, size_wa, rd_addr;
   logic [SIZE_W-1:0]     size_wd;
   logic [GRAN_W-1:0]     link_rd;
   logic                  mark_rd;
   logic [SIZE_W-1:0]     size_rd;

   logic                  push_en;
   logic [CLS_W-1:0]      push_cls;
   logic [ADDR_W-1:0]     push_addr;

   logic [REQ_W:0]        s_c, sp7_c, r_c;
   logic [REQ_W-3:0]      cls_full_c;
   logic [ADDR_W-1:0]     start_c;
   logic [SIZE_W-2:0]     fcls_c;

   sca_step_unit u_step (
      .ptr    (ptr_ff),
      .rem    (rem_ff),
      .step   (step_ff),
      .result (step_res)
   );

   sca_ram #(.WIDTH(GRAN_W), .ADDR_BITS(GRAN_W)) u_link (
      .clock (clock), .wr_en (link_we), .wr_addr (link_wa), .wr_data (link_wd),
      .rd_addr (rd_addr), .rd_data (link_rd)
   );

   sca_ram #(.WIDTH(1), .ADDR_BITS(GRAN_W)) u_mark (
      .clock (clock), .wr_en (mark_we), .wr_addr (mark_wa), .wr_data (mark_wd),
      .rd_addr (rd_addr), .rd_data (mark_rd)
   );

   sca_ram #(.WIDTH(SIZE_W), .ADDR_BITS(GRAN_W)) u_size (
      .clock (clock), .wr_en (size_we), .wr_addr (size_wa), .wr_data (size_wd),
      .rd_addr (rd_addr), .rd_data (size_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ADDR_W - 2){1'b0}}, rsp_status_ff, rsp_addr_ff};

   assign s_c        = (REQ_W+1)'(req_ff) + (REQ_W+1)'(HEADER_BYTES);
   assign sp7_c      = s_c + (REQ_W+1)'(GRAN_BYTES - 1);
   assign r_c        = {sp7_c[REQ_W:3], 3'b000};
   assign cls_full_c = sp7_c[REQ_W:3] - 1'b1;
   assign start_c    = ADDR_W'(opened_ff) << BLOCK_SHIFT;
   assign fcls_c     = (SIZE_W-1)'(({1'b0, size_rd} + (SIZE_W+1)'(GRAN_BYTES - 1)) >> 3);

   // list push: new node links to old head, or to itself when list was empty
   always_comb begin
      link_we = push_en;
      link_wa = push_addr[GRAN_W+2:3];
      link_wd = head_ff[push_cls][GRAN_W] ? head_ff[push_cls][GRAN_W-1:0]
                                          : push_addr[GRAN_W+2:3];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      req_in        = req_ff;
      fa_in         = fa_ff;
      small_in      = small_ff;
      cls_in        = cls_ff;
      blk_in        = blk_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      cnt_in        = cnt_ff;
      pool_ptr_in   = pool_ptr_ff;
      pool_rem_in   = pool_rem_ff;
      opened_in     = opened_ff;
      head_in       = head_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      push_en       = 1'b0;
      push_cls      = cls_ff;
      push_addr     = ptr_ff;
      mark_we       = 1'b0;
      mark_wa       = blk_ff[GRAN_W+2:3];
      mark_wd       = 1'b0;
      size_we       = 1'b0;
      size_wa       = blk_ff[GRAN_W+2:3];
      size_wd       = step_ff;
      rd_addr       = blk_ff[GRAN_W+2:3];

      unique case (state_ff)
         ST_CLEAR: begin
            mark_we = 1'b1;
            mark_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               req_in   = req_tdata[REQ_W-1:0];
               fa_in    = req_tdata[REQ_W+ADDR_W-1:REQ_W];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (kind_ff == KIND_ALLOC) begin
               small_in = (cls_full_c < (REQ_W-2)'(NUM_CLASSES));
               cls_in   = cls_full_c[CLS_W-1:0];
               step_in  = SIZE_W'(r_c);
               ptr_in   = pool_ptr_ff;
               rem_in   = pool_rem_ff;
               rd_addr  = head_ff[cls_full_c[CLS_W-1:0]][GRAN_W-1:0];
               if (cls_full_c < (REQ_W-2)'(NUM_CLASSES)) begin
                  state_in = head_ff[cls_full_c[CLS_W-1:0]][GRAN_W] ? ST_POP_WAIT
                                                                     : ST_POOL;
               end else if (r_c > (REQ_W+1)'(BLOCK_BYTES)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_TOO_LARGE;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_POOL;
               end
            end else begin
               blk_in  = fa_ff - ADDR_W'(HEADER_BYTES);
               rd_addr = GRAN_W'((fa_ff - ADDR_W'(HEADER_BYTES)) >> 3);
               if (fa_ff < ADDR_W'(HEADER_BYTES) || fa_ff[2:0] != 3'b000) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = '0;
                  rsp_status_in = STATUS_BAD_FREE;
                  state_in      = ST_OUT;
               end else begin
                  state_in = ST_FREE_WAIT;
               end
            end
         end
         ST_POP_WAIT: begin
            blk_in = {head_ff[cls_ff][GRAN_W-1:0], 3'b000};
            head_in[cls_ff] = (link_rd == head_ff[cls_ff][GRAN_W-1:0])
                              ? '0 : {1'b1, link_rd};
            state_in = ST_GRANT;
         end
         ST_POOL: begin
            if (step_res.ge) begin
               blk_in = ptr_ff;
               if (small_ff) begin
                  ptr_in   = step_res.sum;
                  rem_in   = step_res.diff;
                  cnt_in   = CNT_W'(1);
                  state_in = ST_CARVE;
               end else begin
                  pool_ptr_in = step_res.sum;
                  pool_rem_in = step_res.diff;
                  state_in    = ST_GRANT;
               end
            end else if (opened_ff >= OPEN_W'(NUM_BLOCKS)) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_NO_MEMORY;
               state_in      = ST_OUT;
            end else begin
               opened_in = opened_ff + 1'b1;
               if (small_ff) begin
                  ptr_in      = start_c;
                  rem_in      = SIZE_W'(BLOCK_BYTES);
                  pool_ptr_in = start_c;
                  pool_rem_in = SIZE_W'(BLOCK_BYTES);
               end else begin
                  blk_in   = start_c;
                  state_in = ST_GRANT;
               end
            end
         end
         ST_CARVE: begin
            if (cnt_ff < CNT_W'(CARVE_COUNT) && step_res.ge) begin
               push_en  = 1'b1;
               head_in[cls_ff] = {1'b1, ptr_ff[GRAN_W+2:3]};
               ptr_in   = step_res.sum;
               rem_in   = step_res.diff;
               cnt_in   = cnt_ff + 1'b1;
            end else begin
               pool_ptr_in = ptr_ff;
               pool_rem_in = rem_ff;
               state_in    = ST_GRANT;
            end
         end
         ST_GRANT: begin
            mark_we       = 1'b1;
            mark_wd       = 1'b1;
            size_we       = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_addr_in   = blk_ff + ADDR_W'(HEADER_BYTES);
            rsp_status_in = STATUS_OK;
            state_in      = ST_OUT;
         end
         ST_FREE_WAIT: begin
            if (!mark_rd) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = STATUS_BAD_FREE;
               state_in      = ST_OUT;
            end else begin
               mark_we = 1'b1;
               if (fcls_c >= (SIZE_W-1)'(1) && fcls_c <= (SIZE_W-1)'(NUM_CLASSES)) begin
                  push_en   = 1'b1;
                  push_cls  = CLS_W'(fcls_c - 1'b1);
                  push_addr = blk_ff;
                  head_in[CLS_W'(fcls_c - 1'b1)] = {1'b1, blk_ff[GRAN_W+2:3]};
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = blk_ff;
                  rsp_status_in = STATUS_OK;
                  state_in      = ST_OUT;
               end else begin
                  ptr_in   = blk_ff;
                  rem_in   = size_rd;
                  step_in  = SIZE_W'(LARGEST);
                  cls_in   = CLS_W'(NUM_CLASSES - 1);
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (rem_ff >= SIZE_W'(GRAN_BYTES)) begin
               if (step_res.ge) begin
                  push_en = 1'b1;
                  head_in[cls_ff] = {1'b1, ptr_ff[GRAN_W+2:3]};
                  ptr_in  = step_res.sum;
                  rem_in  = step_res.diff;
               end else begin
                  cls_in  = cls_ff - 1'b1;
                  step_in = step_ff - SIZE_W'(GRAN_BYTES);
               end
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = blk_ff;
               rsp_status_in = STATUS_OK;
               state_in      = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pool_ptr_ff  <= '0;
         pool_rem_ff  <= '0;
         opened_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_ptr_ff  <= pool_ptr_in;
         pool_rem_ff  <= pool_rem_in;
         opened_ff    <= opened_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
      kind_ff       <= kind_in;
      req_ff        <= req_in;
      fa_ff         <= fa_in;
      small_ff      <= small_in;
      cls_ff        <= cls_in;
      blk_ff        <= blk_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule
